/* rtl/core/gta_pkg.sv */
package gta_pkg;

   localparam int POS_W      = 24;
   localparam int DIFF_W     = 25;
   localparam int SQ_W       = 50;
   localparam int DIST_W     = 50;
   localparam int HALF_W     = 25;
   localparam int SCORE_W    = 16;
   localparam int SCORE_SQ_W = 32;
   localparam int PP_W       = HALF_W + SCORE_SQ_W;
   localparam int FULL_W     = PP_W + HALF_W;
   localparam int COST_W     = 64;
   localparam int LABEL_W    = 32;
   localparam int FUNC_W     = 2;
   localparam int SLOT_OUT_W = 6;
   localparam int GATE_W     = 64;

   localparam logic [GATE_W-1:0] GATE_RESET = 64'd17179869184;

   localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DETECT = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_RESULT
   } state_type;

   function automatic logic [DIFF_W-1:0] abs_diff(logic signed [POS_W-1:0] a,
                                                   logic signed [POS_W-1:0] b);
      logic signed [DIFF_W-1:0] d;
      d = DIFF_W'(a) - DIFF_W'(b);
      return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
   endfunction

endpackage

/* rtl/core/greedy_track_association.sv */
// Greedy nearest-neighbor association of detections to predicted tracks. A frame-start
// item (func 0) empties the track table, load items (func 1) append tracks until the
// table holds MAX_TRACKS entries, and each detection (func 2) produces one response:
// the label of the unclaimed track with the least squared distance times squared score
// when that cost is below csr gate_squared, else a fresh label from a wrapping counter.
// A detection scans the track table: one stored track enters the pipelined cost unit
// (three squarers, a score squarer, a split 50x32 multiply, saturation and a running
// minimum compare) per cycle, then the pipeline drains and the label is read from the
// table. The block accepts no new item while a detection is in progress; a finished
// response waits in the output register while the next items are taken.
module greedy_track_association #(
   parameter int MAX_TRACKS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [gta_pkg::GATE_W-1:0]             csr_wr_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [gta_pkg::FUNC_W-1:0]             req_func,
   input  logic [gta_pkg::LABEL_W-1:0]            req_track_id,
   input  logic signed [gta_pkg::POS_W-1:0]       req_pos_x,
   input  logic signed [gta_pkg::POS_W-1:0]       req_pos_y,
   input  logic signed [gta_pkg::POS_W-1:0]       req_pos_z,
   input  logic [gta_pkg::SCORE_W-1:0]            req_score,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [gta_pkg::LABEL_W-1:0]            rsp_assigned_id,
   output logic                                   rsp_is_new,
   output logic [gta_pkg::SLOT_OUT_W-1:0]         rsp_track_slot
);
   import gta_pkg::*;

   localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int CNT_W = $clog2(MAX_TRACKS + 1);

   // track table
   logic [3*POS_W-1:0]   pos_mem   [MAX_TRACKS];
   logic [SCORE_W-1:0]   score_mem [MAX_TRACKS];
   logic [LABEL_W-1:0]   label_mem [MAX_TRACKS];
   logic                 claim_mem [MAX_TRACKS];

   state_type            state_ff, state_in;
   logic [GATE_W-1:0]    gate_ff;
   logic [CNT_W-1:0]     track_count_ff;
   logic [LABEL_W-1:0]   next_label_ff;
   logic [CNT_W-1:0]     scan_idx_ff;

   logic signed [POS_W-1:0] det_x_ff, det_y_ff, det_z_ff;

   logic                 req_xfer, load_ok, issue, pipe_busy, out_free, hit;
   logic [IDX_W-1:0]     load_addr, rd_addr;

   // cost pipeline
   logic                 v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic [IDX_W-1:0]     slot1_ff, slot2_ff, slot3_ff, slot4_ff, slot5_ff, slot6_ff;
   logic [3*POS_W-1:0]   pos_rd_ff;
   logic [SCORE_W-1:0]   score_rd_ff, score2_ff;
   logic                 claim_rd_ff;
   logic [DIFF_W-1:0]    mag_x_ff, mag_y_ff, mag_z_ff;
   logic [SQ_W-1:0]      sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SCORE_SQ_W-1:0] ssq3_ff, ssq4_ff;
   logic [DIST_W-1:0]    dist_ff;
   logic [PP_W-1:0]      pp_lo_ff, pp_hi_ff;
   logic [FULL_W-1:0]    cost_full;
   logic [COST_W-1:0]    cost_ff;

   logic                 found_ff;
   logic [COST_W-1:0]    best_cost_ff;
   logic [IDX_W-1:0]     best_slot_ff;
   logic                 hit_ff;
   logic [LABEL_W-1:0]   label_rd_ff;

   logic                 rsp_valid_ff;
   logic [LABEL_W-1:0]   rsp_id_ff;
   logic                 rsp_new_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign load_ok   = req_xfer && (req_func == FUNC_LOAD) &&
                      (track_count_ff < CNT_W'(MAX_TRACKS));
   assign load_addr = track_count_ff[IDX_W-1:0];
   assign rd_addr   = scan_idx_ff[IDX_W-1:0];
   assign issue     = (state_ff == ST_SCAN) && (scan_idx_ff < track_count_ff);
   assign pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff || v5_ff || v6_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign hit       = found_ff && (best_cost_ff < gate_ff);
   assign cost_full = {pp_hi_ff, {HALF_W{1'b0}}} + FULL_W'(pp_lo_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_func == FUNC_DETECT)) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!issue && !pipe_busy) state_in = ST_DECIDE;
         end
         ST_DECIDE: state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff        <= GATE_RESET;
         track_count_ff <= '0;
         next_label_ff  <= '0;
         scan_idx_ff    <= '0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) gate_ff <= csr_wr_data;
         if (req_xfer && (req_func == FUNC_START)) track_count_ff <= '0;
         if (load_ok) track_count_ff <= track_count_ff + CNT_W'(1);
         if (req_xfer && (req_func == FUNC_DETECT)) begin
            scan_idx_ff <= '0;
            found_ff    <= 1'b0;
         end
         if (issue) scan_idx_ff <= scan_idx_ff + CNT_W'(1);
         if (v6_ff && (!found_ff || (cost_ff < best_cost_ff))) found_ff <= 1'b1;
         if ((state_ff == ST_RESULT) && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (!hit_ff) next_label_ff <= next_label_ff + LABEL_W'(1);
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff && !claim_rd_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // table writes and registered reads
   always_ff @(posedge clock) begin
      if (load_ok) begin
         pos_mem[load_addr]   <= {req_pos_x, req_pos_y, req_pos_z};
         score_mem[load_addr] <= req_score;
         label_mem[load_addr] <= req_track_id;
      end
      pos_rd_ff   <= pos_mem[rd_addr];
      score_rd_ff <= score_mem[rd_addr];
      label_rd_ff <= label_mem[best_slot_ff];
   end

   always_ff @(posedge clock) begin
      if (load_ok) begin
         claim_mem[load_addr] <= 1'b0;
      end else if ((state_ff == ST_RESULT) && out_free && hit_ff) begin
         claim_mem[best_slot_ff] <= 1'b1;
      end
      claim_rd_ff <= claim_mem[rd_addr];
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_xfer && (req_func == FUNC_DETECT)) begin
         det_x_ff <= req_pos_x;
         det_y_ff <= req_pos_y;
         det_z_ff <= req_pos_z;
      end
      slot1_ff  <= rd_addr;
      mag_x_ff  <= abs_diff(det_x_ff, pos_rd_ff[3*POS_W-1:2*POS_W]);
      mag_y_ff  <= abs_diff(det_y_ff, pos_rd_ff[2*POS_W-1:POS_W]);
      mag_z_ff  <= abs_diff(det_z_ff, pos_rd_ff[POS_W-1:0]);
      score2_ff <= score_rd_ff;
      slot2_ff  <= slot1_ff;
      sq_x_ff   <= SQ_W'(mag_x_ff) * SQ_W'(mag_x_ff);
      sq_y_ff   <= SQ_W'(mag_y_ff) * SQ_W'(mag_y_ff);
      sq_z_ff   <= SQ_W'(mag_z_ff) * SQ_W'(mag_z_ff);
      ssq3_ff   <= SCORE_SQ_W'(score2_ff) * SCORE_SQ_W'(score2_ff);
      slot3_ff  <= slot2_ff;
      dist_ff   <= sq_x_ff + sq_y_ff + sq_z_ff;
      ssq4_ff   <= ssq3_ff;
      slot4_ff  <= slot3_ff;
      pp_lo_ff  <= PP_W'(dist_ff[HALF_W-1:0]) * PP_W'(ssq4_ff);
      pp_hi_ff  <= PP_W'(dist_ff[DIST_W-1:HALF_W]) * PP_W'(ssq4_ff);
      slot5_ff  <= slot4_ff;
      // saturate to 64 bits
      cost_ff   <= (|cost_full[FULL_W-1:COST_W]) ? {COST_W{1'b1}} : cost_full[COST_W-1:0];
      slot6_ff  <= slot5_ff;
      if (v6_ff && (!found_ff || (cost_ff < best_cost_ff))) begin
         best_cost_ff <= cost_ff;
         best_slot_ff <= slot6_ff;
      end
      if (state_ff == ST_DECIDE) hit_ff <= hit;
      if ((state_ff == ST_RESULT) && out_free) begin
         if (hit_ff) begin
            rsp_id_ff   <= label_rd_ff;
            rsp_new_ff  <= 1'b0;
            rsp_slot_ff <= SLOT_OUT_W'(best_slot_ff);
         end else begin
            rsp_id_ff   <= next_label_ff;
            rsp_new_ff  <= 1'b1;
            rsp_slot_ff <= '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_assigned_id = rsp_id_ff;
   assign rsp_is_new      = rsp_new_ff;
   assign rsp_track_slot  = rsp_slot_ff;

   assert property (@(posedge clock) disable iff (reset)
      track_count_ff <= CNT_W'(MAX_TRACKS))
      else $error("track count beyond table depth");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("response raised outside result step");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pipe_busy)
      else $error("cost pipeline busy while idle");

endmodule
